@@ sv/ptns_pkg.sv @@
package ptns_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int MAX_NODES_DEF = 8;
    localparam int QDEPTH        = 2;

    typedef enum logic [2:0] {
        OP_NEW_TASK,
        OP_NEW_NODE,
        OP_FINISH,
        OP_DOWN,
        OP_MIGRATE,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        CMD_DEPLOY  = 2'd0,
        CMD_EVICT   = 2'd1,
        CMD_RESUME  = 2'd2,
        CMD_MIGRATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        TS_READY,
        TS_RUNNING,
        TS_STOPPED
    } tstate_t;

    typedef enum logic [1:0] {
        NS_IDLE,
        NS_LOWP,
        NS_BUSY
    } nstate_t;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_TSCAN,
        ES_NSCAN,
        ES_ACT,
        ES_ASSIGN,
        ES_OUT
    } eng_state_t;

    typedef enum logic [3:0] {
        STEP_FIN_NODE,
        STEP_FIN_DROP,
        STEP_DOWN_NODE,
        STEP_DOWN_TASK,
        STEP_MIG_TASK,
        STEP_MIG_DEST,
        STEP_MIG_CUR,
        STEP_SCH_TASK,
        STEP_SCH_OWN,
        STEP_SCH_FREE,
        STEP_SCH_OLD
    } step_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  prio;
        logic [31:0] task_ref;
        logic [15:0] node_sel;
    } req_t;

    typedef struct packed {
        logic [31:0] id;
        logic        prio;
        tstate_t     st;
        logic        has_node;
        logic [15:0] node;
    } task_t;

    typedef struct packed {
        logic [15:0] id;
        nstate_t     st;
        logic        has_task;
        logic [31:0] task_id;
        logic        has_ev;
        logic [31:0] ev;
    } node_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] task_id;
        logic [15:0] node_id;
        logic [15:0] dest;
    } res_t;

endpackage

@@ sv/preemptive_task_node_scheduler.sv @@
// preemptive task / node scheduler
// slave channel s_*: one event request per handshake (new task, new node,
// task finished, node down, migrate); requests land in a two-entry queue
// so the sender is only held off when that queue is full
// master channel m_*: command results; an event gives zero, one or two
// results, m_tlast marks the final one of each event
// an event is decoded, then looked up by scans that step one entry per cycle
// through the task table (two passes, high class then low) and the node
// table; the worst case, a migrate followed by a preempting pass, runs three
// task scans and four node scans, all in the single table scan engine;
// events are handled one at a time
// the scheduling pass runs after every event, also for unused codes
// reset: both tables empty, next task id is one, no pending results
// receiver stall: the result register holds; the engine waits at the end
// of the event, the request queue keeps taking events until full
module preemptive_task_node_scheduler
    import ptns_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // req_type, priority_req, task_ref, target node
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // command, task_id, node_id, dest_node_id
    output logic        m_tlast
);

    logic  q_valid;
    req_t  q_req;
    logic  q_pop;
    res_t  res;

    ptns_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tdata[2:0]),
        .priority_req (s_tdata[4:3]),
        .task_ref     (s_tdata[36:5]),
        .node_sel     (s_tdata[52:37]),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_pop        (q_pop)
    );

    ptns_engine #(
        .MAX_TASKS (MAX_TASKS),
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'd0, res.dest, res.node_id, res.task_id, res.cmd};

endmodule

@@ sv/ptns_front.sv @@
module ptns_front
    import ptns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [1:0]  priority_req,
    input  logic [31:0] task_ref,
    input  logic [15:0] node_sel,
    output logic        q_valid,
    output req_t        q_req,
    input  logic        q_pop
);

    localparam int QW = $clog2(QDEPTH);

    req_t            slot_reg [QDEPTH];
    logic [QW-1:0]   wr_ptr_reg;
    logic [QW-1:0]   rd_ptr_reg;
    logic [QW:0]     cnt_reg;
    req_t            in_req;
    logic            push;
    logic            pop;

    always_comb
    begin
        unique case (req_type)
            3'd0:    in_req.op = OP_NEW_TASK;
            3'd1:    in_req.op = OP_NEW_NODE;
            3'd2:    in_req.op = OP_FINISH;
            3'd3:    in_req.op = OP_DOWN;
            3'd4:    in_req.op = OP_MIGRATE;
            default: in_req.op = OP_NONE;
        endcase
        in_req.prio     = priority_req;
        in_req.task_ref = task_ref;
        in_req.node_sel = node_sel;
    end

    assign in_ready = cnt_reg < (QW+1)'(QDEPTH);
    assign push     = in_valid && in_ready;
    assign q_valid  = cnt_reg != '0;
    assign pop      = q_pop && q_valid;
    assign q_req    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
        end
    end

endmodule

@@ sv/ptns_engine.sv @@
module ptns_engine
    import ptns_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  req_t  q_req,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res,
    output logic  out_last
);

    localparam int TIW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TCW = $clog2(MAX_TASKS + 1);
    localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);

    task_t             task_reg [MAX_TASKS];
    node_t             node_reg [MAX_NODES];

    eng_state_t        state_reg, state_next;
    step_t             step_reg, step_next;
    logic [31:0]       key_reg, key_next;
    logic              find_reg, find_next;
    logic              scan_start;
    req_t              ev_reg;

    logic [TCW-1:0]    t_idx_reg;
    logic [NCW-1:0]    n_idx_reg;
    logic              pass_reg;
    logic              hit_reg;
    logic [TIW-1:0]    t_hit_idx_reg;
    logic [NIW-1:0]    n_hit_idx_reg;
    logic              rdy_reg;
    logic [TIW-1:0]    rdy_idx_reg;
    logic              lowp_reg;
    logic [NIW-1:0]    lowp_idx_reg;
    logic [TIW-1:0]    t_sel_reg;
    logic [NIW-1:0]    k_sel_reg;
    logic [TCW-1:0]    t_cnt_reg;
    logic [NCW-1:0]    n_cnt_reg;
    logic [31:0]       next_id_reg;

    logic              pend_valid_reg;
    res_t              pend_reg;
    logic              sch_valid_reg;
    res_t              sch_reg;
    logic              out_valid_reg;
    res_t              out_reg;
    logic              out_last_reg;
    logic              out_free;

    task_t             t_cur, sel_task, pick_task;
    node_t             n_cur, h_node, k_node, last_node;
    logic              t_in, t_hit_now, t_end;
    logic              n_in, n_hit_now;
    logic [TIW-1:0]    pick_idx;
    logic              pick_any;
    logic [NIW-1:0]    kpick_idx;
    logic              kpick_ok;
    logic              own_ok;
    logic              fin_match;
    logic              mig_ok;
    logic              sel_stopped;
    logic              add_task;
    logic              add_node;
    res_t              assign_res;

    assign t_cur     = task_reg[t_idx_reg[TIW-1:0]];
    assign t_in      = t_idx_reg < t_cnt_reg;
    assign t_hit_now = t_in && (t_cur.prio == pass_reg) &&
                       (find_reg ? (t_cur.id == key_reg) : (t_cur.st == TS_STOPPED));
    assign t_end     = !t_in && pass_reg;

    assign n_cur     = node_reg[n_idx_reg[NIW-1:0]];
    assign n_in      = n_idx_reg < n_cnt_reg;
    assign n_hit_now = n_in &&
                       (find_reg ? (n_cur.id == key_reg[15:0]) : (n_cur.st == NS_IDLE));

    assign h_node    = node_reg[n_hit_idx_reg];
    assign sel_task  = task_reg[t_sel_reg];
    assign k_node    = node_reg[k_sel_reg];
    assign last_node = node_reg[NIW'(n_cnt_reg - 1'b1)];

    assign pick_idx  = hit_reg ? t_hit_idx_reg : rdy_idx_reg;
    assign pick_any  = hit_reg || rdy_reg;
    assign pick_task = task_reg[pick_idx];
    assign kpick_idx = hit_reg ? n_hit_idx_reg : lowp_idx_reg;
    assign kpick_ok  = hit_reg || (lowp_reg && !sel_task.prio);
    assign own_ok    = hit_reg && (h_node.st == NS_IDLE);
    assign fin_match = h_node.has_task && (h_node.task_id == ev_reg.task_ref);
    assign mig_ok    = hit_reg && (h_node.st != NS_BUSY) && sel_task.has_node;
    assign sel_stopped = sel_task.st == TS_STOPPED;

    assign add_task  = (q_req.op == OP_NEW_TASK) && (q_req.prio <= 2'd1) &&
                       (t_cnt_reg < TCW'(MAX_TASKS));
    assign add_node  = (q_req.op == OP_NEW_NODE) && (n_cnt_reg < NCW'(MAX_NODES));

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ES_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        assign_res.task_id = sel_task.id;
        assign_res.node_id = k_node.id;
        assign_res.dest    = '0;
        if (!sel_task.prio && (k_node.st == NS_LOWP))
        begin
            assign_res.cmd = CMD_EVICT;
        end
        else if (sel_stopped && sel_task.has_node && (sel_task.node == k_node.id))
        begin
            assign_res.cmd = CMD_RESUME;
        end
        else if (sel_stopped)
        begin
            assign_res.cmd  = CMD_MIGRATE;
            assign_res.dest = k_node.id;
        end
        else
        begin
            assign_res.cmd = CMD_DEPLOY;
        end
    end

    // next state and scan setup
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        key_next   = key_reg;
        find_next  = find_reg;
        scan_start = 1'b0;
        unique case (state_reg)
            ES_IDLE:
            begin
                if (q_valid)
                begin
                    scan_start = 1'b1;
                    find_next  = 1'b1;
                    unique case (q_req.op)
                        OP_FINISH:
                        begin
                            state_next = ES_NSCAN;
                            key_next   = {16'd0, q_req.node_sel};
                            step_next  = STEP_FIN_NODE;
                        end
                        OP_DOWN:
                        begin
                            state_next = ES_NSCAN;
                            key_next   = {16'd0, q_req.node_sel};
                            step_next  = STEP_DOWN_NODE;
                        end
                        OP_MIGRATE:
                        begin
                            state_next = ES_TSCAN;
                            key_next   = q_req.task_ref;
                            step_next  = STEP_MIG_TASK;
                        end
                        default:
                        begin
                            state_next = ES_TSCAN;
                            find_next  = 1'b0;
                            step_next  = STEP_SCH_TASK;
                        end
                    endcase
                end
            end
            ES_TSCAN:
            begin
                if (t_hit_now || t_end)
                begin
                    state_next = ES_ACT;
                end
            end
            ES_NSCAN:
            begin
                if (n_hit_now || !n_in)
                begin
                    state_next = ES_ACT;
                end
            end
            ES_ACT:
            begin
                // default: start the scheduling pass
                scan_start = 1'b1;
                state_next = ES_TSCAN;
                find_next  = 1'b0;
                step_next  = STEP_SCH_TASK;
                unique case (step_reg)
                    STEP_FIN_NODE:
                    begin
                        if (hit_reg && fin_match)
                        begin
                            find_next = 1'b1;
                            key_next  = ev_reg.task_ref;
                            step_next = STEP_FIN_DROP;
                        end
                        else if (hit_reg && h_node.has_ev)
                        begin
                            find_next = 1'b1;
                            key_next  = h_node.ev;
                            step_next = STEP_FIN_DROP;
                        end
                    end
                    STEP_DOWN_NODE:
                    begin
                        if (hit_reg && h_node.has_task)
                        begin
                            find_next = 1'b1;
                            key_next  = h_node.task_id;
                            step_next = STEP_DOWN_TASK;
                        end
                    end
                    STEP_MIG_TASK:
                    begin
                        if (hit_reg)
                        begin
                            state_next = ES_NSCAN;
                            find_next  = 1'b1;
                            key_next   = {16'd0, ev_reg.node_sel};
                            step_next  = STEP_MIG_DEST;
                        end
                    end
                    STEP_MIG_DEST:
                    begin
                        if (mig_ok)
                        begin
                            state_next = ES_NSCAN;
                            find_next  = 1'b1;
                            key_next   = {16'd0, sel_task.node};
                            step_next  = STEP_MIG_CUR;
                        end
                    end
                    STEP_SCH_TASK:
                    begin
                        if (!pick_any)
                        begin
                            scan_start = 1'b0;
                            state_next = ES_OUT;
                        end
                        else if (pick_task.st == TS_STOPPED && pick_task.has_node)
                        begin
                            state_next = ES_NSCAN;
                            find_next  = 1'b1;
                            key_next   = {16'd0, pick_task.node};
                            step_next  = STEP_SCH_OWN;
                        end
                        else
                        begin
                            state_next = ES_NSCAN;
                            step_next  = STEP_SCH_FREE;
                        end
                    end
                    STEP_SCH_OWN:
                    begin
                        if (own_ok)
                        begin
                            scan_start = 1'b0;
                            state_next = ES_ASSIGN;
                        end
                        else
                        begin
                            state_next = ES_NSCAN;
                            step_next  = STEP_SCH_FREE;
                        end
                    end
                    STEP_SCH_FREE:
                    begin
                        scan_start = 1'b0;
                        state_next = kpick_ok ? ES_ASSIGN : ES_OUT;
                    end
                    STEP_SCH_OLD:
                    begin
                        scan_start = 1'b0;
                        state_next = ES_OUT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ES_ASSIGN:
            begin
                if (k_node.has_task)
                begin
                    scan_start = 1'b1;
                    state_next = ES_TSCAN;
                    find_next  = 1'b1;
                    key_next   = k_node.task_id;
                    step_next  = STEP_SCH_OLD;
                end
                else
                begin
                    state_next = ES_OUT;
                end
            end
            ES_OUT:
            begin
                if (!pend_valid_reg && !sch_valid_reg)
                begin
                    state_next = ES_IDLE;
                end
            end
            default:
            begin
                state_next = ES_IDLE;
            end
        endcase
    end

    // task and node tables
    always_ff @(posedge clk)
    begin
        if (q_pop && add_task)
        begin
            task_reg[t_cnt_reg[TIW-1:0]] <= '{id: next_id_reg, prio: q_req.prio[0],
                                             st: TS_READY, has_node: 1'b0, node: '0};
        end
        if (q_pop && add_node)
        begin
            node_reg[n_cnt_reg[NIW-1:0]] <= '{id: (n_cnt_reg == '0) ? 16'd1
                                                  : last_node.id + 16'd1,
                                             st: NS_IDLE, has_task: 1'b0, task_id: '0,
                                             has_ev: 1'b0, ev: '0};
        end
        if (state_reg == ES_ACT)
        begin
            case (step_reg)
                STEP_FIN_NODE:
                begin
                    if (hit_reg && fin_match)
                    begin
                        node_reg[n_hit_idx_reg].st       <= NS_IDLE;
                        node_reg[n_hit_idx_reg].has_task <= 1'b0;
                    end
                    else if (hit_reg && h_node.has_ev)
                    begin
                        node_reg[n_hit_idx_reg].has_ev <= 1'b0;
                    end
                end
                STEP_FIN_DROP:
                begin
                    if (hit_reg)
                    begin
                        for (int i = 0; i < MAX_TASKS - 1; i++)
                        begin
                            if (TIW'(i) >= t_hit_idx_reg)
                            begin
                                task_reg[i] <= task_reg[i+1];
                            end
                        end
                    end
                end
                STEP_DOWN_NODE:
                begin
                    if (hit_reg && !h_node.has_task)
                    begin
                        for (int i = 0; i < MAX_NODES - 1; i++)
                        begin
                            if (NIW'(i) >= n_hit_idx_reg)
                            begin
                                node_reg[i] <= node_reg[i+1];
                            end
                        end
                    end
                end
                STEP_DOWN_TASK:
                begin
                    if (hit_reg)
                    begin
                        task_reg[t_hit_idx_reg].st <= TS_READY;
                    end
                    for (int i = 0; i < MAX_NODES - 1; i++)
                    begin
                        if (NIW'(i) >= k_sel_reg)
                        begin
                            node_reg[i] <= node_reg[i+1];
                        end
                    end
                end
                STEP_MIG_CUR:
                begin
                    if (hit_reg)
                    begin
                        node_reg[k_sel_reg].st           <= NS_BUSY;
                        node_reg[n_hit_idx_reg].st       <= NS_IDLE;
                        node_reg[n_hit_idx_reg].has_task <= 1'b0;
                        task_reg[t_sel_reg].node         <= k_node.id;
                        node_reg[k_sel_reg].has_task     <= 1'b1;
                        node_reg[k_sel_reg].task_id      <= sel_task.id;
                    end
                end
                STEP_SCH_OLD:
                begin
                    if (hit_reg)
                    begin
                        task_reg[t_hit_idx_reg].st <= TS_STOPPED;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ES_ASSIGN)
        begin
            task_reg[t_sel_reg].st       <= TS_RUNNING;
            task_reg[t_sel_reg].has_node <= 1'b1;
            task_reg[t_sel_reg].node     <= k_node.id;
            node_reg[k_sel_reg].st       <= sel_task.prio ? NS_LOWP : NS_BUSY;
            if (k_node.has_task)
            begin
                node_reg[k_sel_reg].has_ev <= 1'b1;
                node_reg[k_sel_reg].ev     <= k_node.task_id;
            end
            node_reg[k_sel_reg].has_task <= 1'b1;
            node_reg[k_sel_reg].task_id  <= sel_task.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ES_IDLE;
            step_reg       <= STEP_SCH_TASK;
            key_reg        <= '0;
            find_reg       <= 1'b0;
            ev_reg         <= '0;
            t_idx_reg      <= '0;
            n_idx_reg      <= '0;
            pass_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            t_hit_idx_reg  <= '0;
            n_hit_idx_reg  <= '0;
            rdy_reg        <= 1'b0;
            rdy_idx_reg    <= '0;
            lowp_reg       <= 1'b0;
            lowp_idx_reg   <= '0;
            t_sel_reg      <= '0;
            k_sel_reg      <= '0;
            t_cnt_reg      <= '0;
            n_cnt_reg      <= '0;
            next_id_reg    <= 32'd1;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            sch_valid_reg  <= 1'b0;
            sch_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            key_reg   <= key_next;
            find_reg  <= find_next;

            if (q_pop)
            begin
                ev_reg <= q_req;
                if (q_req.op == OP_NEW_TASK)
                begin
                    next_id_reg <= next_id_reg + 32'd1;
                end
                if (add_task)
                begin
                    t_cnt_reg <= t_cnt_reg + 1'b1;
                end
                if (add_node)
                begin
                    n_cnt_reg <= n_cnt_reg + 1'b1;
                end
            end

            if (scan_start)
            begin
                t_idx_reg <= '0;
                n_idx_reg <= '0;
                pass_reg  <= 1'b0;
                hit_reg   <= 1'b0;
                rdy_reg   <= 1'b0;
                lowp_reg  <= 1'b0;
            end
            else if (state_reg == ES_TSCAN)
            begin
                if (t_in)
                begin
                    if (t_hit_now)
                    begin
                        hit_reg       <= 1'b1;
                        t_hit_idx_reg <= t_idx_reg[TIW-1:0];
                    end
                    if (!find_reg && (t_cur.prio == pass_reg) && (t_cur.st == TS_READY)
                        && !rdy_reg)
                    begin
                        rdy_reg     <= 1'b1;
                        rdy_idx_reg <= t_idx_reg[TIW-1:0];
                    end
                    t_idx_reg <= t_idx_reg + 1'b1;
                end
                else if (!pass_reg)
                begin
                    pass_reg  <= 1'b1;
                    t_idx_reg <= '0;
                end
            end
            else if (state_reg == ES_NSCAN)
            begin
                if (n_in)
                begin
                    if (n_hit_now)
                    begin
                        hit_reg       <= 1'b1;
                        n_hit_idx_reg <= n_idx_reg[NIW-1:0];
                    end
                    if (!find_reg && (n_cur.st == NS_LOWP) && !lowp_reg)
                    begin
                        lowp_reg     <= 1'b1;
                        lowp_idx_reg <= n_idx_reg[NIW-1:0];
                    end
                    n_idx_reg <= n_idx_reg + 1'b1;
                end
            end

            if (state_reg == ES_ACT)
            begin
                case (step_reg)
                    STEP_FIN_DROP:
                    begin
                        if (hit_reg)
                        begin
                            t_cnt_reg <= t_cnt_reg - 1'b1;
                        end
                    end
                    STEP_DOWN_NODE:
                    begin
                        k_sel_reg <= n_hit_idx_reg;
                        if (hit_reg && !h_node.has_task)
                        begin
                            n_cnt_reg <= n_cnt_reg - 1'b1;
                        end
                    end
                    STEP_DOWN_TASK:
                    begin
                        n_cnt_reg <= n_cnt_reg - 1'b1;
                    end
                    STEP_MIG_TASK:
                    begin
                        t_sel_reg <= t_hit_idx_reg;
                    end
                    STEP_MIG_DEST:
                    begin
                        k_sel_reg <= n_hit_idx_reg;
                    end
                    STEP_MIG_CUR:
                    begin
                        if (hit_reg)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_reg       <= '{cmd: CMD_MIGRATE, task_id: sel_task.id,
                                                node_id: h_node.id, dest: k_node.id};
                        end
                    end
                    STEP_SCH_TASK:
                    begin
                        t_sel_reg <= pick_idx;
                    end
                    STEP_SCH_OWN:
                    begin
                        if (own_ok)
                        begin
                            k_sel_reg <= n_hit_idx_reg;
                        end
                    end
                    STEP_SCH_FREE:
                    begin
                        k_sel_reg <= kpick_idx;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ES_ASSIGN)
            begin
                sch_valid_reg <= 1'b1;
                sch_reg       <= assign_res;
            end

            if (out_free && (state_reg == ES_OUT) && (pend_valid_reg || sch_valid_reg))
            begin
                out_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_reg        <= pend_reg;
                    out_last_reg   <= !sch_valid_reg;
                    pend_valid_reg <= 1'b0;
                end
                else
                begin
                    out_reg       <= sch_reg;
                    out_last_reg  <= 1'b1;
                    sch_valid_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_task_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        t_cnt_reg <= TCW'(MAX_TASKS))
        else $error("task count beyond table");

    a_node_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        n_cnt_reg <= NCW'(MAX_NODES))
        else $error("node count beyond table");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ES_IDLE) |-> (!pend_valid_reg && !sch_valid_reg))
        else $error("results left over at idle");

    a_sch_from_assign: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sch_valid_reg) |-> $past(state_reg == ES_ASSIGN))
        else $error("schedule result without assignment");

endmodule
